[src/softmax_normalizer_defines.svh]
// Assertion helpers for the softmax normalizer
`ifndef SOFTMAX_NORMALIZER_DEFINES_SVH
`define SOFTMAX_NORMALIZER_DEFINES_SVH
`ifndef SYNTHESIS
`define SMX_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define SMX_ASSERT_R(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SMX_ASSERT(label, clk, rst, prop)
`define SMX_ASSERT_R(label, clk, prop)
`endif
`endif

[src/smx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package smx_pkg;
  localparam int MaxN = 64;
  localparam int AW = $clog2(MaxN);
  localparam int CW = $clog2(MaxN + 1);
  localparam int SW = CW + 17;
  localparam int QD = 16;
  localparam int QAW = $clog2(QD);

  // Request from front to back: one vector ready to normalize
  typedef struct packed {
    logic signed [15:0] mx;
    logic [CW-1:0]      count;
    logic               dropped;
  } smx_job_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_SUM, BK_DIV, BK_EMIT, BK_DONE
  } bk_state_t;
endpackage
`default_nettype wire

[src/smx_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface smx_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] logit;
  logic is_last;
  modport source (output valid, logit, is_last, input ready);
  modport sink (input valid, logit, is_last, output ready);
endinterface

interface smx_out_if;
  logic valid;
  logic ready;
  logic [15:0] prob;
  logic [5:0] position;
  logic final_prob;
  logic overflowed;
  modport source (output valid, prob, position, final_prob, overflowed, input ready);
  modport sink (input valid, prob, position, final_prob, overflowed, output ready);
endinterface
`default_nettype wire

[src/smx_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module smx_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[src/smx_exp.sv]
`timescale 1ns / 1ps
`default_nettype none
// Pipelined exp(-d) in Q1.16, one argument each cycle
module smx_exp (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic [16:0] d,
  output logic             out_valid,
  output logic [16:0]      e
);
  import smx_pkg::*;
  localparam int NS = 8;
  logic [NS-1:0] vld;
  logic [33:0] y;
  logic [15:0] f [6];
  logic [17:0] k [6];
  logic [16:0] p [6];
  logic [16:0] coef [5];
  logic [33:0] prod [5];

  assign coef[0] = 17'd630;
  assign coef[1] = 17'd3638;
  assign coef[2] = 17'd15743;
  assign coef[3] = 17'd45426;
  assign coef[4] = 17'd65536;

  // Horner products, one per stage
  always_comb begin
    for (int s = 0; s < 5; s++) prod[s] = {17'd0, p[s]} * {18'd0, f[s]};
  end

  // Advance the pipeline
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[NS-2:0], in_valid};
    y <= ({17'd0, d} * 34'd94548 + 34'd128) >> 8;
    f[0] <= y[15:0];
    k[0] <= y[33:16];
    p[0] <= 17'd87;
    for (int s = 0; s < 5; s++) begin
      f[s+1] <= f[s];
      k[s+1] <= k[s];
      p[s+1] <= coef[s] - prod[s][32:16];
    end
    if (k[5] > 18'd16) e <= '0;
    else e <= p[5] >> k[5][4:0];
  end
  assign out_valid = vld[NS-1];
endmodule
`default_nettype wire

[src/smx_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// Load logits into the store and track the max; post one job per vector
module smx_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  smx_in_if.sink                     in_ch,
  output logic                       we,
  output logic [smx_pkg::AW-1:0]     waddr,
  output logic [15:0]                wdata,
  output logic                       job_valid,
  input  wire logic                  job_ready,
  output smx_pkg::smx_job_t          job
);
  import smx_pkg::*;
  logic signed [15:0] running_max;
  logic [CW-1:0] item_count;
  logic dropped_flag;
  logic acc, room;
  logic signed [15:0] mx_next;

  // Accept only while a job can be posted for a last word
  assign in_ch.ready = job_ready;
  assign acc = in_ch.valid & in_ch.ready;
  assign room = item_count < CW'(MaxN);
  assign we = acc & room;
  assign waddr = item_count[AW-1:0];
  assign wdata = in_ch.logit;
  assign mx_next = (room && in_ch.logit > running_max) ? in_ch.logit : running_max;
  assign job_valid = acc & in_ch.is_last;
  assign job.mx = mx_next;
  assign job.count = room ? item_count + CW'(1) : item_count;
  assign job.dropped = dropped_flag | ~room;

  always_ff @(posedge clk) begin
    if (rst || job_valid) begin
      running_max <= 16'sh8000;
      item_count <= '0;
      dropped_flag <= 1'b0;
    end else if (acc) begin
      running_max <= mx_next;
      if (room) item_count <= item_count + CW'(1);
      else dropped_flag <= 1'b1;
    end
  end
endmodule
`default_nettype wire

[src/smx_back.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "softmax_normalizer_defines.svh"
// Sum exp terms, take the reciprocal, then emit probabilities
module smx_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               job_valid,
  output logic                    job_ready,
  input  wire smx_pkg::smx_job_t  job,
  output logic [smx_pkg::AW-1:0]  raddr,
  input  wire logic [15:0]        rdata,
  smx_out_if.source               out_ch
);
  import smx_pkg::*;
  bk_state_t state, state_next;
  smx_job_t cur;
  logic [CW-1:0] issued, got;
  logic [SW-1:0] exp_sum;
  logic [38:0] rem;
  logic [38:0] inv;
  logic [5:0] dstep;
  logic rd_v, ex_v;
  logic [16:0] dval, e;
  logic [3:0] infl;
  logic [QAW:0] qcnt;
  logic [16:0] qe [QD];
  logic [QAW-1:0] qw, qr;
  logic [CW-1:0] opos;
  logic [55:0] pr;
  logic [16:0] oprob;
  logic ovalid;
  logic phase_issue;
  logic pop;
  logic [39:0] trial;

  assign job_ready = (state == BK_IDLE);
  assign raddr = issued[AW-1:0];
  assign dval = 17'({cur.mx[15], cur.mx}) - 17'({rdata[15], rdata});
  assign phase_issue = (state == BK_SUM && issued < cur.count) ||
                       (state == BK_EMIT && issued < cur.count &&
                        ((QAW+2)'(qcnt) + (QAW+2)'(infl) + (QAW+2)'(rd_v)) <
                        (QAW+2)'(QD));
  assign trial = {rem, 1'b0} - {16'd0, exp_sum};
  assign pop = (state == BK_EMIT) && (qcnt != '0) && (!ovalid || out_ch.ready);
  assign pr = {39'd0, qe[qr]} * {17'd0, inv} + 56'(1 << 21);

  smx_exp u_exp (.clk, .rst, .in_valid(rd_v), .d(dval), .out_valid(ex_v), .e);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (job_valid) state_next = BK_SUM;
      BK_SUM:  if (got == cur.count) state_next = BK_DIV;
      BK_DIV:  if (dstep == 6'd37) state_next = BK_EMIT;
      BK_EMIT: if (opos == cur.count && (!ovalid || out_ch.ready)) state_next = BK_DONE;
      BK_DONE: state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // Output word
  always_comb begin
    out_ch.valid = ovalid;
    out_ch.prob = (oprob[16]) ? 16'hFFFF : oprob[15:0];
    out_ch.position = 6'(opos - CW'(1));
    out_ch.final_prob = (opos == cur.count);
    out_ch.overflowed = cur.dropped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      rd_v <= 1'b0;
      infl <= '0;
      qcnt <= '0;
      qw <= '0;
      qr <= '0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      rd_v <= phase_issue;
      if (state == BK_IDLE && job_valid) begin
        cur <= job;
        issued <= '0;
        got <= '0;
        exp_sum <= '0;
        opos <= '0;
      end
      if (phase_issue) issued <= issued + CW'(1);
      infl <= infl + {3'd0, rd_v} - {3'd0, ex_v};
      if (state == BK_SUM && ex_v) begin
        exp_sum <= exp_sum + SW'(e);
        got <= got + CW'(1);
      end
      if (state == BK_SUM && got == cur.count) begin
        rem <= 39'd1;
        inv <= '0;
        dstep <= '0;
        issued <= '0;
      end
      // Restoring division of 2^38 by the sum, one bit a cycle
      if (state == BK_DIV) begin
        dstep <= dstep + 6'd1;
        if (!trial[39]) begin
          rem <= trial[38:0];
          inv <= {inv[37:0], 1'b1};
        end else begin
          rem <= {rem[37:0], 1'b0};
          inv <= {inv[37:0], 1'b0};
        end
      end
      // Queue exp terms on the way to the output
      if (state == BK_EMIT && ex_v) begin
        qe[qw] <= e;
        qw <= qw + QAW'(1);
      end
      // Load the output register or drop the word once taken
      if (pop) begin
        oprob <= (pr[55:38] != '0) ? 17'h10000 : pr[38:22];
        ovalid <= 1'b1;
        opos <= opos + CW'(1);
        qr <= qr + QAW'(1);
      end else if (out_ch.ready) begin
        ovalid <= 1'b0;
      end
      qcnt <= qcnt + (QAW+1)'(state == BK_EMIT && ex_v) - (QAW+1)'(pop);
    end
  end

  `SMX_ASSERT(a_sum_min, clk, rst, (state == BK_DIV) |-> (exp_sum >= SW'(65536)))
  `SMX_ASSERT(a_q_bound, clk, rst, qcnt <= (QAW+1)'(QD))
  `SMX_ASSERT(a_idle_out, clk, rst, (state == BK_IDLE) |-> !ex_v)
endmodule
`default_nettype wire

[src/softmax_normalizer.sv]
`timescale 1ns / 1ps
`default_nettype none
// Softmax normalizer.
// Input channel carries one signed Q8.8 logit per word with an is_last mark.
// Logits are written into a 64-entry store while the max is tracked; words
// past capacity are dropped and the vector is flagged overflowed.
// The last word hands the vector to the back end, which runs each entry
// through an exp pipeline to form the sum, then a bit-serial reciprocal,
// then a second exp pass that feeds a 16-word queue ahead of the output
// register, one probability per cycle while the receiver is ready.
// Input ready is low while a vector is being normalized.
// When the receiver stalls, the output word holds and the queue throttles
// the exp pass; nothing is lost. Synchronous reset discards any partly
// loaded vector and returns the back end to idle.
module softmax_normalizer (
  input  wire logic clk,
  input  wire logic rst,
  smx_in_if.sink    in_ch,
  smx_out_if.source out_ch
);
  import smx_pkg::*;
  logic we, job_valid, job_ready;
  logic [AW-1:0] waddr, raddr;
  logic [15:0] wdata, rdata;
  smx_job_t job;

  smx_front u_front (.clk, .rst, .in_ch, .we, .waddr, .wdata,
                     .job_valid, .job_ready, .job);
  smx_ram #(.Width(16), .Depth(MaxN)) u_ram (.clk, .we, .waddr, .wdata,
                     .raddr, .rdata);
  smx_back u_back (.clk, .rst, .job_valid, .job_ready, .job, .raddr, .rdata, .out_ch);
endmodule
`default_nettype wire

[tb/sv/softmax_normalizer_tb.sv]
`timescale 1ns / 1ps
module softmax_normalizer_tb;
  import smx_pkg::*;

  logic clk;
  logic rst;
  smx_in_if  in_ch ();
  smx_out_if out_ch ();

  softmax_normalizer u_top (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  typedef struct {
    logic [15:0] prob;
    logic [5:0]  position;
    logic        final_prob;
    logic        overflowed;
  } prob_word_t;

  prob_word_t prob_q[$];

  // predictor state for the vector being collected
  logic signed [15:0] vec_logit[MaxN];
  logic signed [15:0] vec_max;
  int                 vec_count;
  logic               vec_dropped;

  int  errors;
  int  words_sent;
  int  probs_seen;
  int  vectors_sent;
  bit  idle_en;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("** softmax_normalizer: FAILED **");
    $finish;
  end

  // exp(logit - mx) in Q1.16
  function automatic logic [16:0] exp_weight(logic signed [15:0] lg, logic signed [15:0] mx);
    logic [63:0] d;
    logic [63:0] y;
    logic [63:0] k;
    logic [63:0] f;
    logic [63:0] p;
    d = 64'(int'(mx) - int'(lg));
    y = (d * 64'd94548 + 64'd128) >> 8;
    k = y >> 16;
    f = y & 64'hFFFF;
    p = 64'd87;
    p = 64'd630 - ((p * f) >> 16);
    p = 64'd3638 - ((p * f) >> 16);
    p = 64'd15743 - ((p * f) >> 16);
    p = 64'd45426 - ((p * f) >> 16);
    p = 64'd65536 - ((p * f) >> 16);
    if (k > 64'd16) return 17'd0;
    return 17'(p >> k);
  endfunction

  function automatic void clear_vector();
    vec_max = -16'sd32768;
    vec_count = 0;
    vec_dropped = 1'b0;
  endfunction

  // store one logit; on the last one queue every probability
  function automatic void predict_word(logic signed [15:0] lg, logic lst);
    logic [63:0] sum;
    logic [63:0] inv;
    logic [63:0] p;
    prob_word_t w;
    if (vec_count < MaxN) begin
      vec_logit[vec_count] = lg;
      vec_count++;
      if (lg > vec_max) vec_max = lg;
    end else begin
      vec_dropped = 1'b1;
    end
    if (!lst) return;
    sum = 0;
    for (int i = 0; i < vec_count; i++) sum += exp_weight(vec_logit[i], vec_max);
    inv = (sum != 0) ? (64'd1 << 38) / sum : 64'd0;
    for (int i = 0; i < vec_count; i++) begin
      p = (64'(exp_weight(vec_logit[i], vec_max)) * inv + (64'd1 << 21)) >> 22;
      if (p > 64'd65535) p = 64'd65535;
      w.prob = p[15:0];
      w.position = i[5:0];
      w.final_prob = (i + 1 == vec_count);
      w.overflowed = vec_dropped;
      prob_q.push_back(w);
    end
    clear_vector();
  endfunction

  // valid stays high after a word is taken unless an idle burst follows
  task automatic send_word(logic signed [15:0] lg, logic lst);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.logit <= lg;
    in_ch.is_last <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_word(lg, lst);
    words_sent++;
    if (lst) vectors_sent++;
  endtask

  task automatic send_vector(int n, int lo, int hi);
    for (int i = 0; i < n; i++)
      send_word(16'($urandom_range(0, hi - lo) + lo), i == n - 1);
  endtask

  // receiver stalls in bursts
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 5) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // compare each accepted probability with the oldest expectation
  always @(posedge clk) begin
    prob_word_t exp_w;
    if (!rst && out_ch.valid && out_ch.ready) begin
      probs_seen++;
      if (prob_q.size() == 0) begin
        $display("%0t: unexpected word prob=%0d pos=%0d", $time, out_ch.prob,
                 out_ch.position);
        errors++;
      end else begin
        exp_w = prob_q.pop_front();
        if (out_ch.prob !== exp_w.prob) begin
          $display("%0t: prob expected %0d actual %0d", $time, exp_w.prob, out_ch.prob);
          errors++;
        end
        if (out_ch.position !== exp_w.position) begin
          $display("%0t: position expected %0d actual %0d", $time, exp_w.position,
                   out_ch.position);
          errors++;
        end
        if (out_ch.final_prob !== exp_w.final_prob) begin
          $display("%0t: final_prob expected %0b actual %0b", $time, exp_w.final_prob,
                   out_ch.final_prob);
          errors++;
        end
        if (out_ch.overflowed !== exp_w.overflowed) begin
          $display("%0t: overflowed expected %0b actual %0b", $time, exp_w.overflowed,
                   out_ch.overflowed);
          errors++;
        end
      end
    end
  end

  task automatic test_extremes();
    send_word(16'sh7FFF, 1'b1);
    send_word(-16'sd32768, 1'b1);
    send_word(16'sh7FFF, 1'b0);
    send_word(-16'sd32768, 1'b1);
    send_word(16'sh0000, 1'b0);
    send_word(16'shFFFF, 1'b0);
    send_word(16'sh5555, 1'b0);
    send_word(16'shAAAA, 1'b1);
  endtask

  task automatic test_ties();
    send_word(16'sh0100, 1'b0);
    send_word(16'sh0100, 1'b0);
    send_word(16'sh0100, 1'b0);
    send_word(16'sh00F0, 1'b1);
  endtask

  // fill the store, then overflow it, last word among the dropped
  task automatic test_overflow();
    for (int i = 0; i < MaxN + 3; i++)
      send_word(16'($urandom_range(0, 2047) - 1024), i == MaxN + 2);
  endtask

  task automatic test_random();
    int n;
    while (words_sent < 390) begin
      case ($urandom_range(0, 9))
        0: n = MaxN;
        1: n = MaxN + $urandom_range(1, 4);
        default: n = $urandom_range(1, 12);
      endcase
      if ($urandom_range(0, 2) == 0) send_vector(n, -32768, 32767);
      else send_vector(n, -1536, 1536);
    end
  endtask

  task automatic test_unpaced();
    idle_en = 1'b0;
    for (int v = 0; v < 4; v++) send_vector($urandom_range(1, 20), -2048, 2048);
  endtask

  initial begin
    int waited;
    errors = 0;
    words_sent = 0;
    probs_seen = 0;
    vectors_sent = 0;
    idle_en = 1'b1;
    clear_vector();
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.logit = '0;
    in_ch.is_last = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_ties();
    test_overflow();
    test_random();
    test_unpaced();
    in_ch.valid <= 1'b0;
    waited = 0;
    while (prob_q.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);
    $display("Sent %0d logits in %0d vectors, checked %0d probabilities.", words_sent,
             vectors_sent, probs_seen);
    $display("Covered field extremes, ties, store overflow and random stalls.");
    if (errors == 0 && prob_q.size() == 0) begin
      $display("** softmax_normalizer: PASSED **");
    end else begin
      $display("** softmax_normalizer: FAILED **");
    end
    $finish;
  end
endmodule
